// File: src/ipid_pkg.sv
`timescale 1ns / 1ps

package ipid_pkg;

    // Palette storage
    localparam logic [8:0] PAL_DEPTH = 9'd256;
    localparam int PAL_AW = (PAL_DEPTH > 9'd1) ? $clog2(PAL_DEPTH) : 1;

    // Header layout, by byte position
    localparam logic [3:0] HDR_POS_MAGIC_END = 4'd4;
    localparam logic [3:0] HDR_POS_WIDTH_LO  = 4'd4;
    localparam logic [3:0] HDR_POS_WIDTH_HI  = 4'd5;
    localparam logic [3:0] HDR_POS_HEIGHT_LO = 4'd6;
    localparam logic [3:0] HDR_POS_HEIGHT_HI = 4'd7;
    localparam logic [3:0] HDR_POS_COUNT     = 4'd8;
    localparam logic [3:0] HDR_POS_LAST      = 4'd11;

    localparam logic [8:0] FULL_COUNT = 9'd256;

    localparam logic [7:0] MAGIC [4] = '{8'h4C, 8'h47, 8'h42, 8'h31};

    // Configuration register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam int   APB_AW     = 3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PALETTE = 2'd1,
        PH_PIXELS  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_OK    = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_MAGIC = 2'd1,
        ERR_DIM   = 2'd2,
        ERR_LEN   = 2'd3
    } err_t;

    // Per-byte request from the parser to the lookup and output stage
    typedef struct packed {
        logic              pix;
        logic              stat;
        kind_t             kind;
        err_t              err;
        logic [PAL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [PAL_AW-1:0] wr_addr;
        logic [31:0]       wr_data;
    } lookup_req_t;

endpackage

// File: src/ipid_if.sv
`timescale 1ns / 1ps

// Input byte channel.
interface ipid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel.
interface ipid_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] pixel_rgba;
    logic [1:0]  error_code;
    logic        end_of_run;

    modport source (output valid, output result_kind, output pixel_rgba,
                    output error_code, output end_of_run, input ready);
    modport sink (input valid, input result_kind, input pixel_rgba,
                  input error_code, input end_of_run, output ready);
endinterface

// File: src/ipid_apb_regs.sv
`timescale 1ns / 1ps

module ipid_apb_regs
    import ipid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       exp_width,
    output logic [15:0]       exp_height
);

    logic        wr_en;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd256;
            height_reg <= 16'd64;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[15:0];
            else
                height_reg <= pwdata[15:0];
        end
    end

    // Read mux.
    always_comb
    begin
        if (paddr[2] == REG_HEIGHT)
            prdata = {16'd0, height_reg};
        else
            prdata = {16'd0, width_reg};
    end

    assign exp_width  = width_reg;
    assign exp_height = height_reg;

endmodule

// File: src/ipid_parser.sv
`timescale 1ns / 1ps

module ipid_parser
    import ipid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ipid_in_if.sink     in_ch,
    input  logic        take_ok,
    input  logic [15:0] exp_width,
    input  logic [15:0] exp_height,
    output lookup_req_t req
);

    logic        accept;
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] hdr_width_reg, hdr_width_next;
    logic [15:0] hdr_height_reg, hdr_height_next;
    logic [8:0]  entry_count_reg, entry_count_next;
    logic [7:0]  pal_entry_reg, pal_entry_next;
    logic [1:0]  pal_part_reg, pal_part_next;
    logic [23:0] partial_reg, partial_next;
    err_t        fault_reg, fault_next;
    logic [31:0] pix_count_reg, pix_count_next;
    logic [31:0] pixels_reg;
    logic        pix_lt;
    logic        ok_len;
    logic [7:0]  b;

    assign in_ch.ready = take_ok;
    assign accept      = in_ch.valid && take_ok;
    assign b           = in_ch.data_byte;
    assign pix_lt      = pix_count_reg < pixels_reg;

    // Pixel count of the blob, registered after the multiplier.
    always_ff @(posedge clk)
    begin
        pixels_reg <= 32'(hdr_width_reg) * 32'(hdr_height_reg);
    end

    // Next blob state and the request for this byte.
    always_comb
    begin
        phase_next       = phase_reg;
        hdr_pos_next     = hdr_pos_reg;
        hdr_width_next   = hdr_width_reg;
        hdr_height_next  = hdr_height_reg;
        entry_count_next = entry_count_reg;
        pal_entry_next   = pal_entry_reg;
        pal_part_next    = pal_part_reg;
        partial_next     = partial_reg;
        fault_next       = fault_reg;
        pix_count_next   = pix_count_reg;
        ok_len           = 1'b0;
        req              = '0;
        req.kind         = KIND_PIXEL;
        req.err          = ERR_NONE;

        unique case (phase_reg)
            PH_HEADER:
            begin
                hdr_pos_next = hdr_pos_reg + 4'd1;
                if (hdr_pos_reg < HDR_POS_MAGIC_END)
                begin
                    if (b != MAGIC[hdr_pos_reg[1:0]] && fault_next == ERR_NONE)
                        fault_next = ERR_MAGIC;
                end
                else if (hdr_pos_reg == HDR_POS_WIDTH_LO)
                    hdr_width_next = {8'd0, b};
                else if (hdr_pos_reg == HDR_POS_WIDTH_HI)
                    hdr_width_next = {b, hdr_width_reg[7:0]};
                else if (hdr_pos_reg == HDR_POS_HEIGHT_LO)
                    hdr_height_next = {8'd0, b};
                else if (hdr_pos_reg == HDR_POS_HEIGHT_HI)
                begin
                    hdr_height_next = {b, hdr_height_reg[7:0]};
                    if ((hdr_width_reg != exp_width || hdr_height_next != exp_height)
                        && fault_next == ERR_NONE)
                        fault_next = ERR_DIM;
                end
                else if (hdr_pos_reg == HDR_POS_COUNT)
                    entry_count_next = (b == 8'd0) ? FULL_COUNT : {1'b0, b};
                else if (hdr_pos_reg == HDR_POS_LAST)
                begin
                    phase_next   = PH_PALETTE;
                    hdr_pos_next = '0;
                end
            end
            PH_PALETTE:
            begin
                pal_part_next = pal_part_reg + 2'd1;
                unique case (pal_part_reg)
                    2'd0: partial_next = {16'd0, b};
                    2'd1: partial_next = {8'd0, b, partial_reg[7:0]};
                    2'd2: partial_next = {b, partial_reg[15:0]};
                    default:
                    begin
                        req.wr_en      = accept && ({1'b0, pal_entry_reg} < PAL_DEPTH);
                        req.wr_addr    = pal_entry_reg[PAL_AW-1:0];
                        req.wr_data    = {b, partial_reg};
                        pal_entry_next = pal_entry_reg + 8'd1;
                        if ({1'b0, pal_entry_reg} + 9'd1 >= entry_count_reg)
                        begin
                            phase_next = PH_PIXELS;
                            ok_len     = (pixels_reg == 32'd0);
                        end
                    end
                endcase
            end
            PH_PIXELS:
            begin
                if (!pix_lt)
                begin
                    if (fault_next == ERR_NONE)
                        fault_next = ERR_LEN;
                end
                else
                begin
                    pix_count_next = pix_count_reg + 32'd1;
                    ok_len         = (pix_count_next == pixels_reg);
                    if (fault_reg == ERR_NONE)
                    begin
                        req.pix = accept;
                        if ({1'b0, b} < entry_count_reg && {1'b0, b} < PAL_DEPTH)
                            req.rd_addr = b[PAL_AW-1:0];
                    end
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        // Closing status on the last byte, then back to a fresh blob.
        if (in_ch.last_byte)
        begin
            if (!ok_len && fault_next == ERR_NONE)
                fault_next = ERR_LEN;
            req.stat         = accept;
            req.kind         = (fault_next == ERR_NONE) ? KIND_OK : KIND_ERR;
            req.err          = fault_next;
            phase_next       = PH_HEADER;
            hdr_pos_next     = '0;
            hdr_width_next   = '0;
            hdr_height_next  = '0;
            entry_count_next = '0;
            pal_entry_next   = '0;
            pal_part_next    = '0;
            partial_next     = '0;
            fault_next       = ERR_NONE;
            pix_count_next   = '0;
        end
    end

    // Blob state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hdr_pos_reg     <= '0;
            hdr_width_reg   <= '0;
            hdr_height_reg  <= '0;
            entry_count_reg <= '0;
            pal_entry_reg   <= '0;
            pal_part_reg    <= '0;
            partial_reg     <= '0;
            fault_reg       <= ERR_NONE;
            pix_count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            hdr_pos_reg     <= hdr_pos_next;
            hdr_width_reg   <= hdr_width_next;
            hdr_height_reg  <= hdr_height_next;
            entry_count_reg <= entry_count_next;
            pal_entry_reg   <= pal_entry_next;
            pal_part_reg    <= pal_part_next;
            partial_reg     <= partial_next;
            fault_reg       <= fault_next;
            pix_count_reg   <= pix_count_next;
        end
    end

endmodule

// File: src/ipid_lookup_out.sv
`timescale 1ns / 1ps

module ipid_lookup_out
    import ipid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lookup_req_t req,
    output logic        take_ok,
    ipid_out_if.source  out_ch
);

    logic [31:0] pal_mem [0:PAL_DEPTH-1];
    logic [31:0] rdata_reg;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_pix_reg, s1_pix_next;
    logic        s1_stat_reg, s1_stat_next;
    kind_t       s1_kind_reg;
    err_t        s1_err_reg;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [31:0] out_rgba_reg;
    err_t        out_err_reg;
    logic        out_eor_reg;

    logic        out_free;
    logic        move;
    logic        s1_done;
    logic        load;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign move     = s1_valid_reg && out_free;
    assign s1_done  = move && !(s1_pix_reg && s1_stat_reg);
    assign take_ok  = !s1_valid_reg || s1_done;
    assign load     = req.pix || req.stat;

    // Palette memory: one write port from the parser, one registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            pal_mem[req.wr_addr] <= req.wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (req.pix)
            rdata_reg <= pal_mem[req.rd_addr];
    end

    // Stage 1 holds up to two results of one byte; the pixel goes first.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_pix_next   = s1_pix_reg;
        s1_stat_next  = s1_stat_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
            s1_pix_next   = req.pix;
            s1_stat_next  = req.stat;
        end
        else if (s1_done)
            s1_valid_next = 1'b0;
        else if (move)
            s1_pix_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pix_reg   <= 1'b0;
            s1_stat_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_pix_reg   <= s1_pix_next;
            s1_stat_reg  <= s1_stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_kind_reg <= req.kind;
            s1_err_reg  <= req.err;
        end
    end

    // Output register.
    assign out_valid_next = move || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            if (s1_pix_reg)
            begin
                out_kind_reg <= KIND_PIXEL;
                out_rgba_reg <= rdata_reg;
                out_err_reg  <= ERR_NONE;
                out_eor_reg  <= !s1_stat_reg;
            end
            else
            begin
                out_kind_reg <= s1_kind_reg;
                out_rgba_reg <= '0;
                out_err_reg  <= s1_err_reg;
                out_eor_reg  <= 1'b1;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_kind = out_kind_reg;
    assign out_ch.pixel_rgba  = out_rgba_reg;
    assign out_ch.error_code  = out_err_reg;
    assign out_ch.end_of_run  = out_eor_reg;

    // A held stage always carries at least one result.
    a_s1_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_pix_reg || s1_stat_reg))
        else $error("stage 1 valid with no result");

    // A byte with pixel and status sends the status in a later beat.
    a_pair_split: assert property (@(posedge clk) disable iff (!rst_n)
        (move && s1_pix_reg && s1_stat_reg && !load)
        |=> (s1_valid_reg && !s1_pix_reg && s1_stat_reg))
        else $error("status lost after pixel beat");

    // Pixel beats carry no error code.
    a_pixel_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PIXEL) |-> (out_err_reg == ERR_NONE))
        else $error("pixel beat with error code");

    // Status beats close the run and carry no colour.
    a_status_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != KIND_PIXEL)
        |-> (out_eor_reg && out_rgba_reg == 32'd0))
        else $error("status beat malformed");

    // New work is taken only when stage 1 can hold it.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !move) |-> !load)
        else $error("stage 1 overwritten while stalled");

endmodule

// File: src/indexed_palette_image_decoder.sv
`timescale 1ns / 1ps

// Indexed palette image decoder.
// in_ch carries the blob one byte per beat (data_byte, last_byte). The
// 12-byte header is checked against the frame width and frame height
// registers (APB, byte addresses 0 and 4), the palette is stored in a
// 256-entry memory, and each index byte within the frame produces one
// pixel beat on out_ch with its 32-bit colour. The byte marked last adds a
// status beat (success or error with error_code); after an error no more
// pixels are sent for that blob.
// Path: a byte's results wait in stage 1 (the colour in the palette read
// register), then in the output register, which drives out_ch.
// Throughput: one byte per cycle while out_ch does not stall; a last byte
// that is also a pixel yields two beats and holds the input until its
// pixel beat has moved on.
// When out_ch stalls, the output register and the stage behind it hold
// their beats, and in_ch.ready drops once the stage behind is full.
// Reset clears the blob state and sets the registers to 256 x 64; palette
// contents are not cleared and are always written before they are read.
module indexed_palette_image_decoder
    import ipid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    ipid_in_if.sink           in_ch,
    ipid_out_if.source        out_ch
);

    logic [15:0] exp_width;
    logic [15:0] exp_height;
    logic        take_ok;
    lookup_req_t req;

    ipid_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .exp_width  (exp_width),
        .exp_height (exp_height)
    );

    ipid_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take_ok    (take_ok),
        .exp_width  (exp_width),
        .exp_height (exp_height),
        .req        (req)
    );

    ipid_lookup_out u_lookup_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .take_ok (take_ok),
        .out_ch  (out_ch)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ipid_pkg::*;

    localparam int DIR_ROWS       = 27;
    localparam int DIR_SPLIT      = 9;
    localparam int SWEEPS         = 9;
    localparam int SWEEP_BYTES    = 50;
    localparam int BIG_SWEEP      = 3;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOW_LIMIT     = 10;

    localparam logic [63:0] HDR_BYTES = 64'd12;
    localparam logic [7:0]  BLOB_TAG [4] = '{8'h4C, 8'h47, 8'h42, 8'h31};

    typedef enum logic [1:0] {
        STG_HEADER,
        STG_PALETTE,
        STG_PIXELS
    } blob_stage_t;

    // One input beat, with an optional status result fixed by hand.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        kind_t      kind;
        err_t       err;
    } blob_byte_t;

    // One result beat as it should appear on the output channel.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] rgba;
        err_t        err;
        logic        eor;
    } colour_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    ipid_in_if  in_ch ();
    ipid_out_if out_ch ();

    indexed_palette_image_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #1 clk = ~clk;

    // Decoder state as the bench sees it.
    logic [15:0]  cfg_w;
    logic [15:0]  cfg_h;
    blob_stage_t  stage;
    logic [32:0]  blob_pos;
    logic [15:0]  hdr_w;
    logic [15:0]  hdr_h;
    logic [8:0]   pal_count;
    logic [23:0]  pal_part;
    logic [31:0]  pal_mem [256];
    err_t         blob_fault;

    colour_beat_t step_beats [$];
    colour_beat_t pending_beats [$];

    blob_byte_t   dir_rows [DIR_ROWS];
    logic [15:0]  sweep_w [SWEEPS];
    logic [15:0]  sweep_h [SWEEPS];

    int  mismatch_count = 0;
    int  beat_count = 0;
    int  sent_bytes = 0;
    int  burst_left = 0;
    bit  hold_req = 1'b0;

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch: %s", what);
    endtask

    function automatic void flag_error(input err_t code);
        if (blob_fault == ERR_NONE)
            blob_fault = code;
    endfunction

    function automatic void clear_blob_state();
        stage      = STG_HEADER;
        blob_pos   = '0;
        hdr_w      = '0;
        hdr_h      = '0;
        pal_count  = '0;
        pal_part   = '0;
        blob_fault = ERR_NONE;
    endfunction

    // Work out the result beats that one blob byte causes.
    task automatic decode_byte(input logic [7:0] d, input logic l);
        logic [63:0]  pos;
        logic [63:0]  pixels;
        logic [63:0]  off;
        logic [63:0]  want;
        logic [8:0]   idx;
        colour_beat_t beat;
        step_beats.delete();
        pos = 64'(blob_pos);
        pixels = 64'(hdr_w) * 64'(hdr_h);
        case (stage)
            STG_HEADER:
            begin
                if (pos < 64'd4)
                begin
                    if (d != BLOB_TAG[pos[1:0]])
                        flag_error(ERR_MAGIC);
                end
                else if (pos == 64'd4)
                    hdr_w = {8'd0, d};
                else if (pos == 64'd5)
                    hdr_w[15:8] = d;
                else if (pos == 64'd6)
                    hdr_h = {8'd0, d};
                else if (pos == 64'd7)
                begin
                    hdr_h[15:8] = d;
                    if (hdr_w != cfg_w || hdr_h != cfg_h)
                        flag_error(ERR_DIM);
                end
                else if (pos == 64'd8)
                    pal_count = (d == 8'd0) ? 9'd256 : {1'b0, d};
                else if (pos == 64'd11)
                    stage = STG_PALETTE;
            end
            STG_PALETTE:
            begin
                off = pos - HDR_BYTES;
                case (off[1:0])
                    2'd0: pal_part = {16'd0, d};
                    2'd1: pal_part[15:8] = d;
                    2'd2: pal_part[23:16] = d;
                    default:
                    begin
                        if ((off >> 2) < 64'd256)
                            pal_mem[off[9:2]] = {d, pal_part};
                        if ((off >> 2) + 64'd1 >= 64'(pal_count))
                            stage = STG_PIXELS;
                    end
                endcase
            end
            default:
            begin
                off = pos - HDR_BYTES - 64'd4 * 64'(pal_count);
                if (off >= pixels)
                    flag_error(ERR_LEN);
                else if (blob_fault == ERR_NONE)
                begin
                    idx = {1'b0, d};
                    if (idx >= pal_count)
                        idx = 9'd0;
                    beat.kind = KIND_PIXEL;
                    beat.rgba = pal_mem[idx[7:0]];
                    beat.err  = ERR_NONE;
                    beat.eor  = !l;
                    step_beats.push_back(beat);
                end
            end
        endcase

        if (blob_pos != '1)
            blob_pos = blob_pos + 33'd1;

        // The last byte closes the blob with a status beat.
        if (l)
        begin
            want = HDR_BYTES + 64'd4 * 64'(pal_count) + pixels;
            if (stage == STG_HEADER || 64'(blob_pos) != want)
                flag_error(ERR_LEN);
            beat.kind = (blob_fault == ERR_NONE) ? KIND_OK : KIND_ERR;
            beat.rgba = 32'd0;
            beat.err  = blob_fault;
            beat.eor  = 1'b1;
            step_beats.push_back(beat);
            clear_blob_state();
        end
    endtask

    // Offer one byte, in bursts with random gaps, and record what it should cause.
    task automatic push_byte(input blob_byte_t row);
        int unsigned  gap;
        colour_beat_t beat;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 24);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= row.data;
        in_ch.last_byte <= row.last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        sent_bytes++;

        decode_byte(row.data, row.last);
        if (row.fixed)
        begin
            beat.kind = row.kind;
            beat.rgba = 32'd0;
            beat.err  = row.err;
            beat.eor  = 1'b1;
            pending_beats.push_back(beat);
        end
        else
        begin
            foreach (step_beats[i])
                pending_beats.push_back(step_beats[i]);
        end
    endtask

    // Stop offering and let every expected beat come out.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic sel, input logic [15:0] wval,
                            output logic [31:0] rval);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'd0, wval};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rval = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program the frame size and read it back.
    task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
        logic [31:0] rd;
        apb_xfer(1'b1, REG_WIDTH, w, rd);
        apb_xfer(1'b1, REG_HEIGHT, h, rd);
        cfg_w = w;
        cfg_h = h;
        apb_xfer(1'b0, REG_WIDTH, 16'd0, rd);
        if (rd[15:0] !== w)
            note_mismatch($sformatf("width register: expected %0d, got %0d", w, rd[15:0]));
        apb_xfer(1'b0, REG_HEIGHT, 16'd0, rd);
        if (rd[15:0] !== h)
            note_mismatch($sformatf("height register: expected %0d, got %0d", h, rd[15:0]));
    endtask

    // Build one blob: mostly well formed against the current frame size, with
    // corrupted tags, wrong sizes, short and long bodies and plain noise mixed in.
    // A full-palette blob asks the receiver to hold off once its pixels begin.
    task automatic send_blob(input bit full_palette);
        int unsigned shape;
        int unsigned len_mode;
        int unsigned len;
        int unsigned npix;
        int unsigned pal_bytes;
        int unsigned cnt;
        int unsigned k;
        int          bad_pos;
        logic [15:0] bw;
        logic [15:0] bh;
        logic [7:0]  cnt_byte;
        logic [7:0]  bad_xor;
        logic [63:0] px;
        blob_byte_t  r;
        shape = full_palette ? 50 : $urandom_range(0, 99);
        r = '0;

        // Noise: a short run of random bytes.
        if (shape < 5)
        begin
            len = $urandom_range(1, 16);
            for (k = 0; k < len; k++)
            begin
                r.data = 8'($urandom_range(0, 255));
                r.last = (k == len - 1);
                push_byte(r);
            end
            return;
        end

        bad_pos = (shape < 11) ? $urandom_range(0, 3) : -1;
        bad_xor = 8'($urandom_range(1, 255));
        bw = cfg_w;
        bh = cfg_h;
        if (shape >= 11 && shape < 18)
        begin
            if ($urandom_range(0, 1) == 1)
                bw = 16'($urandom_range(0, 65535));
            else
                bh = bh ^ (16'd1 << $urandom_range(0, 15));
        end

        if (full_palette)
            cnt_byte = 8'd0;
        else if ($urandom_range(0, 29) == 0)
            cnt_byte = 8'($urandom_range(17, 255));
        else
            cnt_byte = 8'($urandom_range(1, 16));
        cnt = (cnt_byte == 8'd0) ? 256 : cnt_byte;
        pal_bytes = 4 * cnt;

        // Pick the body length; huge frames are always cut short.
        px = 64'(bw) * 64'(bh);
        len_mode = full_palette ? 0 : $urandom_range(0, 99);
        if (px > 64'd64)
            npix = $urandom_range(0, 40);
        else if (len_mode < 75)
            npix = 32'(px);
        else if (len_mode < 83)
            npix = 32'(px) + $urandom_range(1, 3);
        else if (len_mode < 90 && px > 0)
            npix = $urandom_range(0, 32'(px) - 1);
        else
            npix = 32'(px);
        len = 12 + pal_bytes + npix;
        if (len_mode >= 90 && len_mode < 95)
            len = $urandom_range(1, 12);
        else if (len_mode >= 95)
            len = 12 + $urandom_range(1, pal_bytes);

        for (k = 0; k < len; k++)
        begin
            if (full_palette && k == 12 + pal_bytes)
                hold_req = 1'b1;
            if (k < 4)
                r.data = BLOB_TAG[k] ^ ((int'(k) == bad_pos) ? bad_xor : 8'h00);
            else if (k == 4)
                r.data = bw[7:0];
            else if (k == 5)
                r.data = bw[15:8];
            else if (k == 6)
                r.data = bh[7:0];
            else if (k == 7)
                r.data = bh[15:8];
            else if (k == 8)
                r.data = cnt_byte;
            else if (k < 12 + pal_bytes)
                r.data = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 6) != 0)
                r.data = 8'($urandom_range(0, cnt - 1));
            else
                r.data = 8'($urandom_range(0, 255));
            r.last = (k == len - 1);
            push_byte(r);
        end
    endtask

    // Check every result beat against the oldest expected one.
    always @(posedge clk)
    begin : result_check
        colour_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beat_count++;
            if (pending_beats.size() == 0)
                note_mismatch($sformatf("beat %0d unexpected: kind %0d rgba %h err %0d eor %0b",
                                        beat_count, out_ch.result_kind, out_ch.pixel_rgba,
                                        out_ch.error_code, out_ch.end_of_run));
            else
            begin
                want = pending_beats.pop_front();
                if (out_ch.result_kind !== want.kind || out_ch.pixel_rgba !== want.rgba ||
                    out_ch.error_code !== want.err || out_ch.end_of_run !== want.eor)
                    note_mismatch($sformatf(
                        "beat %0d: expected kind %0d rgba %h err %0d eor %0b, got %0d %h %0d %0b",
                        beat_count, want.kind, want.rgba, want.err, want.eor,
                        out_ch.result_kind, out_ch.pixel_rgba, out_ch.error_code,
                        out_ch.end_of_run));
            end
        end
    end

    // The receiver switches between stall patterns, and holds off once on request.
    initial
    begin : rx_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned cyc;
        span = 0;
        cyc = 0;
        mode = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(32, 200);
                    cyc = 0;
                end
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ((cyc % 7) < 4);
                    default: out_ch.ready <= ($urandom_range(0, 15) != 0);
                endcase
                span--;
                cyc++;
                @(posedge clk);
            end
        end
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main_seq
        int i;
        int s;
        int start_bytes;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;

        cfg_w = 16'd256;
        cfg_h = 16'd64;
        clear_blob_state();
        foreach (pal_mem[j])
            pal_mem[j] = '0;

        // Directed bytes. The first rows run at the reset frame size of 256 x 64:
        // a lone wrong tag byte, then a header with all-ones sizes. The rest run
        // at 1 x 1 with one palette entry: an out-of-range index, then an excess
        // pixel marked last.
        dir_rows = '{
            '{8'h00, 1'b1, 1'b1, KIND_ERR,   ERR_MAGIC},
            '{8'h4C, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h47, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h42, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h31, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b1, 1'b1, KIND_ERR,   ERR_DIM},
            '{8'h4C, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h47, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h42, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h31, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h01, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h01, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h01, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h80, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h80, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h7F, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
            '{8'h00, 1'b1, 1'b1, KIND_ERR,   ERR_LEN}
        };

        // Frame sizes for the random part, the extremes among them.
        sweep_w = '{16'd3, 16'd0, 16'd65535, 16'd4, 16'd0, 16'd1, 16'd65535, 16'd7, 16'd2};
        sweep_h = '{16'd2, 16'd0, 16'd0, 16'd4, 16'd65535, 16'd1, 16'd65535, 16'd3, 16'd5};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_SPLIT)
            begin
                settle();
                set_frame(16'd1, 16'd1);
            end
            push_byte(dir_rows[i]);
        end
        settle();

        // Random blobs, one frame size at a time. One sweep starts with a full
        // 256-entry palette, and the receiver holds off once its pixels begin,
        // so the input backs up.
        for (s = 0; s < SWEEPS; s++)
        begin
            set_frame(sweep_w[s], sweep_h[s]);
            start_bytes = sent_bytes;
            if (s == BIG_SWEEP)
                send_blob(1'b1);
            while (sent_bytes - start_bytes < SWEEP_BYTES)
                send_blob(1'b0);
            settle();
        end

        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
